// ===== hdl/pps_pkg.sv =====
// shared types and constants of the priority scheduler
package pps_pkg;

  localparam int ACT_W   = 2;
  localparam int ID_W    = 8;
  localparam int TIME_W  = 16;
  localparam int BURST_W = 12;
  localparam int PRIO_W  = 4;

  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;

  localparam logic [TIME_W-1:0] TIME_MAX = 16'hFFFF;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [TIME_W-1:0]  arrival;
    logic [BURST_W-1:0] burst;
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] remaining;
  } slot_t;

endpackage

// ===== hdl/pps_if.sv =====
// request and result channel interfaces of the priority scheduler
interface pps_in_if;
  logic                        valid;
  logic                        ready;
  logic [pps_pkg::ACT_W-1:0]   action;
  logic [pps_pkg::ID_W-1:0]    task_id;
  logic [pps_pkg::TIME_W-1:0]  arrival_time;
  logic [pps_pkg::BURST_W-1:0] burst_length;
  logic [pps_pkg::PRIO_W-1:0]  priority_level;

  modport source (
    output valid, action, task_id, arrival_time, burst_length, priority_level,
    input  ready
  );
  modport sink (
    input  valid, action, task_id, arrival_time, burst_length, priority_level,
    output ready
  );
endinterface

interface pps_out_if;
  logic                       valid;
  logic                       ready;
  logic [pps_pkg::TIME_W-1:0] tick_time;
  logic                       idle;
  logic [pps_pkg::ID_W-1:0]   running_id;
  logic                       finished;
  logic [pps_pkg::TIME_W-1:0] completion_time;
  logic [pps_pkg::TIME_W-1:0] wait_time;
  logic [pps_pkg::TIME_W-1:0] turnaround_time;
  logic                       all_done;

  modport source (
    output valid, tick_time, idle, running_id, finished, completion_time,
           wait_time, turnaround_time, all_done,
    input  ready
  );
  modport sink (
    input  valid, tick_time, idle, running_id, finished, completion_time,
           wait_time, turnaround_time, all_done,
    output ready
  );
endinterface

// ===== hdl/pps_pick.sv =====
// running best-slot tracker fed one table entry per cycle during a scan
module pps_pick #(
  parameter int IDX_W = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       ent_vld,
  input  pps_pkg::slot_t             ent,
  input  logic [IDX_W-1:0]           ent_idx,
  input  logic [pps_pkg::TIME_W-1:0] now,
  output logic                       found,
  output logic [IDX_W-1:0]           best_idx
);

  logic                      found_r, found_nxt;
  logic [IDX_W-1:0]          best_idx_r, best_idx_nxt;
  logic [pps_pkg::PRIO_W:0]  best_pri_r, best_pri_nxt;
  logic                      elig;

  assign elig = ent_vld && (ent.arrival <= now) && (ent.remaining != '0) &&
                ({1'b0, ent.prio} < best_pri_r);

  always_comb begin
    found_nxt    = found_r;
    best_idx_nxt = best_idx_r;
    best_pri_nxt = best_pri_r;
    if (start) begin
      found_nxt    = 1'b0;
      best_idx_nxt = '0;
      best_pri_nxt = {1'b1, {pps_pkg::PRIO_W{1'b0}}};
    end else if (elig) begin
      found_nxt    = 1'b1;
      best_idx_nxt = ent_idx;
      best_pri_nxt = {1'b0, ent.prio};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
    best_idx_r <= best_idx_nxt;
    best_pri_r <= best_pri_nxt;
  end

  assign found    = found_r;
  assign best_idx = best_idx_r;

endmodule

// ===== hdl/preemptive_priority_scheduler_core.sv =====
// top level of the tick-driven preemptive priority scheduler
//
//   port     dir  carries
//   in_req   in   request: load task, tick or clear, with task fields
//   out_res  out  one result per tick request: running task and finish stats
//
// load and clear requests are taken in idle and leave the input ready; a tick holds the
// input not ready until its result is emitted, through the scan that reads the slot
// table one entry per cycle from one memory port with a registered read, then (if a task
// is eligible) a read-modify-write of the chosen slot; an empty table skips the reads.
// reset clears counters and time; slot contents stay undefined until loaded.
// a finished result waits in the output register while new requests are taken;
// a tick only stalls at its end if the previous result has not been taken.
module preemptive_priority_scheduler_core #(
  parameter int MAX_TASKS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  pps_in_if.sink    in_req,
  pps_out_if.source out_res
);

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);
  localparam int TW    = pps_pkg::TIME_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_READ = 3'd2;
  localparam logic [2:0] ST_UPD  = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  loaded_r, loaded_nxt;
  logic [CNT_W-1:0]  done_r, done_nxt;
  logic [TW-1:0]     time_r, time_nxt;
  logic [CNT_W-1:0]  iss_r, iss_nxt;
  logic              rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]  rd_idx_r, rd_idx_nxt;

  logic [TW-1:0]     comp_r, comp_nxt;
  logic [TW-1:0]     wait_r, wait_nxt;
  logic [pps_pkg::BURST_W-1:0] burst_r, burst_nxt;
  logic [pps_pkg::ID_W-1:0]    rid_r, rid_nxt;
  logic              fin_r, fin_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [TW-1:0]     o_tick_r, o_tick_nxt;
  logic              o_idle_r, o_idle_nxt;
  logic [pps_pkg::ID_W-1:0] o_rid_r, o_rid_nxt;
  logic              o_fin_r, o_fin_nxt;
  logic [TW-1:0]     o_comp_r, o_comp_nxt;
  logic [TW-1:0]     o_wait_r, o_wait_nxt;
  logic [TW-1:0]     o_turn_r, o_turn_nxt;
  logic              o_alld_r, o_alld_nxt;

  pps_pkg::slot_t    mem [MAX_TASKS];
  pps_pkg::slot_t    rdata_r;
  pps_pkg::slot_t    mem_wdata;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  mem_raddr;

  logic              in_fire;
  logic              pick_start;
  logic              found;
  logic [IDX_W-1:0]  best_idx;

  logic [pps_pkg::BURST_W-1:0] rem_dec;
  logic [TW:0]       used;
  logic [TW:0]       comp_ext;
  logic [TW:0]       turn_sum;

  assign in_req.ready = (state_r == ST_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  pps_pick #(
    .IDX_W (IDX_W)
  ) u_pick (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (pick_start),
    .ent_vld  (rd_vld_r),
    .ent      (rdata_r),
    .ent_idx  (rd_idx_r),
    .now      (time_r),
    .found    (found),
    .best_idx (best_idx)
  );

  assign rem_dec  = rdata_r.remaining - pps_pkg::BURST_W'(1);
  assign used     = (TW+1)'(rdata_r.burst) + (TW+1)'(rdata_r.arrival);
  assign comp_ext = {1'b0, comp_r};
  assign turn_sum = {1'b0, wait_r} + (TW+1)'(burst_r);

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    done_nxt      = done_r;
    time_nxt      = time_r;
    iss_nxt       = iss_r;
    rd_vld_nxt    = 1'b0;
    rd_idx_nxt    = rd_idx_r;
    comp_nxt      = comp_r;
    wait_nxt      = wait_r;
    burst_nxt     = burst_r;
    rid_nxt       = rid_r;
    fin_nxt       = fin_r;
    out_valid_nxt = out_valid_r && !out_res.ready;
    o_tick_nxt    = o_tick_r;
    o_idle_nxt    = o_idle_r;
    o_rid_nxt     = o_rid_r;
    o_fin_nxt     = o_fin_r;
    o_comp_nxt    = o_comp_r;
    o_wait_nxt    = o_wait_r;
    o_turn_nxt    = o_turn_r;
    o_alld_nxt    = o_alld_r;
    mem_we        = 1'b0;
    mem_waddr     = loaded_r[IDX_W-1:0];
    mem_wdata     = '{id:        in_req.task_id,
                      arrival:   in_req.arrival_time,
                      burst:     in_req.burst_length,
                      prio:      in_req.priority_level,
                      remaining: in_req.burst_length};
    mem_raddr     = '0;
    pick_start    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_req.action)
            pps_pkg::ACT_LOAD: begin
              if (loaded_r < CNT_W'(MAX_TASKS)) begin
                mem_we     = 1'b1;
                loaded_nxt = loaded_r + CNT_W'(1);
                if (in_req.burst_length == '0) begin
                  done_nxt = done_r + CNT_W'(1);
                end
              end
            end
            pps_pkg::ACT_TICK: begin
              iss_nxt    = '0;
              fin_nxt    = 1'b0;
              pick_start = 1'b1;
              state_nxt  = ST_SCAN;
            end
            pps_pkg::ACT_CLEAR: begin
              loaded_nxt = '0;
              done_nxt   = '0;
              time_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (iss_r < loaded_r) begin
          mem_raddr  = iss_r[IDX_W-1:0];
          rd_vld_nxt = 1'b1;
          rd_idx_nxt = iss_r[IDX_W-1:0];
          iss_nxt    = iss_r + CNT_W'(1);
        end else if (!rd_vld_r) begin
          state_nxt = found ? ST_READ : ST_EMIT;
        end
      end
      ST_READ: begin
        mem_raddr = best_idx;
        comp_nxt  = (time_r == pps_pkg::TIME_MAX) ? pps_pkg::TIME_MAX :
                    time_r + TW'(1);
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        mem_we    = 1'b1;
        mem_waddr = best_idx;
        mem_wdata = rdata_r;
        mem_wdata.remaining = rem_dec;
        rid_nxt   = rdata_r.id;
        burst_nxt = rdata_r.burst;
        fin_nxt   = (rem_dec == '0);
        wait_nxt  = (comp_ext > used) ? TW'(comp_ext - used) : '0;
        if (rem_dec == '0) begin
          done_nxt = done_r + CNT_W'(1);
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt = 1'b1;
          o_tick_nxt    = time_r;
          o_idle_nxt    = !found;
          o_rid_nxt     = found ? rid_r : '0;
          o_fin_nxt     = found && fin_r;
          o_comp_nxt    = (found && fin_r) ? comp_r : '0;
          o_wait_nxt    = (found && fin_r) ? wait_r : '0;
          o_turn_nxt    = !(found && fin_r) ? '0 :
                          turn_sum[TW] ? pps_pkg::TIME_MAX : turn_sum[TW-1:0];
          o_alld_nxt    = (done_r == loaded_r);
          time_nxt      = (time_r == pps_pkg::TIME_MAX) ? pps_pkg::TIME_MAX :
                          time_r + TW'(1);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      done_r      <= '0;
      time_r      <= '0;
      iss_r       <= '0;
      rd_vld_r    <= 1'b0;
      fin_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      done_r      <= done_nxt;
      time_r      <= time_nxt;
      iss_r       <= iss_nxt;
      rd_vld_r    <= rd_vld_nxt;
      fin_r       <= fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r <= rd_idx_nxt;
    comp_r   <= comp_nxt;
    wait_r   <= wait_nxt;
    burst_r  <= burst_nxt;
    rid_r    <= rid_nxt;
    o_tick_r <= o_tick_nxt;
    o_idle_r <= o_idle_nxt;
    o_rid_r  <= o_rid_nxt;
    o_fin_r  <= o_fin_nxt;
    o_comp_r <= o_comp_nxt;
    o_wait_r <= o_wait_nxt;
    o_turn_r <= o_turn_nxt;
    o_alld_r <= o_alld_nxt;
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.tick_time       = o_tick_r;
  assign out_res.idle            = o_idle_r;
  assign out_res.running_id      = o_rid_r;
  assign out_res.finished        = o_fin_r;
  assign out_res.completion_time = o_comp_r;
  assign out_res.wait_time       = o_wait_r;
  assign out_res.turnaround_time = o_turn_r;
  assign out_res.all_done        = o_alld_r;

endmodule
